@@ design/grbf_pkg.sv @@
// Shared types, constants and the power-of-two table of the Gaussian RBF neuron.
package grbf_pkg;

	localparam int EXP_TABLE_ENTRIES = 64;
	localparam int EXP_IDX_W = $clog2(EXP_TABLE_ENTRIES);
	localparam int SCALED_W = 28 + EXP_IDX_W;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int SUM_W = 40;
	localparam int BETA_W = 24;
	localparam int ACT_W = 17;

	localparam logic [SUM_W-1:0] SUM_MAX = '1;
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [63:0] LN2_Q30 = 64'd744261118;
	localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
	localparam logic [ACT_W-1:0] ACT_ONE = 17'd65536;

	typedef struct packed {
		logic signed [15:0] sample_value;
		logic signed [15:0] center_value;
		logic last_element;
	} sample_t;

	typedef struct packed {
		logic [ACT_W-1:0] activation;
		logic sum_saturated;
	} result_t;

	// One finished distance sum handed from the accumulator to the exponential unit.
	typedef struct packed {
		logic [SUM_W-1:0] distance_sum;
		logic clip_seen;
	} vec_sum_t;

	typedef struct packed {
		logic push;
		vec_sum_t entry;
	} queue_push_t;

	typedef struct packed {
		logic almost_full;
		logic full;
		logic not_empty;
	} queue_status_t;

	typedef logic [30:0] pow2_table_t [EXP_TABLE_ENTRIES + 1];

	// Entry i holds 2^-(i/EXP_TABLE_ENTRIES) in Q1.30, built from a truncated
	// alternating series for exp(-t) with integer arithmetic.
	function automatic pow2_table_t build_pow2_table();
		pow2_table_t tab;
		logic [63:0] t;
		logic [63:0] res;
		logic [63:0] term;
		for (int i = 0; i <= EXP_TABLE_ENTRIES; i++) begin
			t = (LN2_Q30 * 64'(i)) / EXP_TABLE_ENTRIES;
			res = ONE_Q30;
			term = ONE_Q30;
			for (int k = 1; k <= 14; k++) begin
				term = ((term * t) >> 30) / 64'(k);
				if ((k & 1) != 0) begin
					res = res - term;
				end else begin
					res = res + term;
				end
			end
			tab[i] = res[30:0];
		end
		tab[0] = ONE_Q30[30:0];
		tab[EXP_TABLE_ENTRIES] = ONE_Q30[31:1];
		return tab;
	endfunction

	localparam pow2_table_t POW2_TABLE = build_pow2_table();

endpackage

@@ design/gaussian_rbf_neuron.sv @@
// Top level of the Gaussian RBF neuron: accumulator, sum queue, exponential unit, beta register.
//
// Usage: stream one vector element per transaction on the sample channel
// (sample_valid, sample_stall, sample_data); the element marked last_element
// closes the vector. One result transaction per vector leaves on the result
// channel (result_valid, result_stall, result_data) carrying exp(-beta*sum)
// in Q1.16 and the saturation flag of the distance sum.
// The accumulator takes one element per cycle while sample_stall is low. The exponential
// unit is a sequencer of short arithmetic steps and takes a new sum from the queue only
// after its previous result has been loaded into the result register.
// A four-entry queue of finished sums lets the accumulator run ahead of the
// exponential unit; sample_stall rises once that queue is nearly full.
// While result_stall is high and a result is valid, the result register holds, the unit
// waits with its next result, and the queue then fills and stalls the sample channel.
// The user must write beta on the beta channel (always ready) only while the block is
// idle; the block itself does not enforce this.
// Reset clears beta to zero, the running sum, the queue and the result valid.
module gaussian_rbf_neuron (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  grbf_pkg::sample_t    sample_data,
	output logic                 result_valid,
	input  logic                 result_stall,
	output grbf_pkg::result_t    result_data,
	input  logic                 beta_valid,
	output logic                 beta_ready,
	input  logic [23:0]          beta_data
);
	import grbf_pkg::*;

	logic [BETA_W-1:0]  beta_q;
	logic               accept;
	queue_push_t        push;
	vec_sum_t           head;
	queue_status_t      q_status;
	logic               pop;

	assign beta_ready = 1'b1;
	assign sample_stall = q_status.almost_full;
	assign accept = sample_valid & ~sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q <= '0;
		end else if (beta_valid && beta_ready) begin
			beta_q <= beta_data;
		end
	end

	grbf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.sample_data (sample_data),
		.push_out    (push)
	);

	grbf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push_in (push),
		.pop     (pop),
		.head    (head),
		.status  (q_status)
	);

	grbf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.beta         (beta_q),
		.head         (head),
		.status       (q_status),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

	// A finished sum must never arrive at a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) q_status.full |-> !push.push)
		else $error("distance sum pushed into a full queue");

	// The exponential unit only takes a sum that is really there.
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> q_status.not_empty)
		else $error("sum popped from an empty queue");

	// The activation never exceeds 1.0.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result_data.activation <= ACT_ONE))
		else $error("activation above one");

endmodule

@@ design/grbf_front.sv @@
// Front end: squares each element difference and accumulates the saturating distance sum.
module grbf_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  grbf_pkg::sample_t       sample_data,
	output grbf_pkg::queue_push_t   push_out
);
	import grbf_pkg::*;

	logic                     valid_s1;
	logic [31:0]              sq_s1;
	logic                     last_s1;
	logic [SUM_W-1:0]         sum_q;
	logic                     clip_q;

	logic signed [16:0]       diff;
	logic [15:0]              mag;
	logic [SUM_W:0]           total;
	logic [SUM_W-1:0]         new_sum;
	logic                     new_clip;

	always_comb begin
		diff = 17'(sample_data.sample_value) - 17'(sample_data.center_value);
		mag = diff[16] ? 16'(-diff) : diff[15:0];
		total = {1'b0, sum_q} + (SUM_W + 1)'(sq_s1);
		new_sum = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
		new_clip = clip_q | total[SUM_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			last_s1 <= accept & sample_data.last_element;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sq_s1 <= 32'(mag) * 32'(mag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			clip_q <= 1'b0;
		end else if (valid_s1) begin
			if (last_s1) begin
				sum_q <= '0;
				clip_q <= 1'b0;
			end else begin
				sum_q <= new_sum;
				clip_q <= new_clip;
			end
		end
	end

	always_comb begin
		push_out.push = valid_s1 & last_s1;
		push_out.entry.distance_sum = new_sum;
		push_out.entry.clip_seen = new_clip;
	end

endmodule

@@ design/grbf_queue.sv @@
// Short queue of finished distance sums between the accumulator and the exponential unit.
module grbf_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  grbf_pkg::queue_push_t     push_in,
	input  logic                      pop,
	output grbf_pkg::vec_sum_t        head,
	output grbf_pkg::queue_status_t   status
);
	import grbf_pkg::*;

	vec_sum_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	always_ff @(posedge clk) begin
		if (push_in.push) begin
			mem_q[wr_ptr_q] <= push_in.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push_in.push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push_in.push, pop})
				2'b10: count_q <= count_q + QCNT_W'(1);
				2'b01: count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_comb begin
		head = mem_q[rd_ptr_q];
		// One slot is held back for the element still in the squaring stage.
		status.almost_full = (count_q >= QCNT_W'(QUEUE_DEPTH - 1));
		status.full = (count_q == QCNT_W'(QUEUE_DEPTH));
		status.not_empty = (count_q != '0);
	end

endmodule

@@ design/grbf_back.sv @@
// Back end: sequenced exp(-beta*sum) evaluation and the result output register.
module grbf_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [23:0]              beta,
	input  grbf_pkg::vec_sum_t       head,
	input  grbf_pkg::queue_status_t  status,
	output logic                     pop,
	output logic                     result_valid,
	input  logic                     result_stall,
	output grbf_pkg::result_t        result_data
);
	import grbf_pkg::*;

	typedef enum logic [8:0] {
		B_IDLE   = 9'b000000001,
		B_MUL_LO = 9'b000000010,
		B_MUL_HI = 9'b000000100,
		B_SUM    = 9'b000001000,
		B_LOG    = 9'b000010000,
		B_LUT    = 9'b000100000,
		B_INTERP = 9'b001000000,
		B_ROUND  = 9'b010000000,
		B_DONE   = 9'b100000000
	} back_state_t;

	back_state_t         state_q;
	logic [SUM_W-1:0]    sum_q;
	logic                clip_q;
	logic [43:0]         p_lo_q;
	logic [43:0]         p_hi_q;
	logic                big_q;
	logic [31:0]         x28_q;
	logic [32:0]         y_q;
	logic [4:0]          n_q;
	logic [30:0]         hi_q;
	logic [30:0]         diff_q;
	logic [27:0]         r_q;
	logic [30:0]         val_q;
	result_t             res_q;
	logic                result_valid_q;
	result_t             result_q;

	logic [63:0]         x_full;
	logic [62:0]         log_prod;
	logic [SCALED_W-1:0] scaled;
	logic [EXP_IDX_W-1:0] idx;
	logic [EXP_IDX_W:0]  lo_idx;
	logic [30:0]         tab_hi;
	logic [30:0]         tab_lo;
	logic [58:0]         interp_prod;
	logic [5:0]          sh;
	logic [45:0]         rounded;
	logic                load_out;

	always_comb begin
		x_full = 64'(p_lo_q) + {p_hi_q, 20'b0};
		log_prod = 63'(x28_q) * 63'(LOG2E_Q30);
		scaled = SCALED_W'(y_q[27:0]) * SCALED_W'(EXP_TABLE_ENTRIES);
		idx = scaled[SCALED_W-1:28];
		lo_idx = {1'b0, idx} + (EXP_IDX_W + 1)'(1);
		tab_hi = POW2_TABLE[idx];
		tab_lo = POW2_TABLE[lo_idx];
		interp_prod = 59'(diff_q) * 59'(r_q);
		sh = 6'd14 + 6'(n_q);
		rounded = (46'(val_q) + (46'd1 << (sh - 6'd1))) >> sh;
		pop = (state_q == B_IDLE) && status.not_empty;
		load_out = (state_q == B_DONE) && (!result_valid_q || !result_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			case (state_q)
				B_IDLE:   if (status.not_empty) state_q <= B_MUL_LO;
				B_MUL_LO: state_q <= B_MUL_HI;
				B_MUL_HI: state_q <= B_SUM;
				B_SUM:    state_q <= B_LOG;
				B_LOG:    state_q <= B_LUT;
				B_LUT:    state_q <= B_INTERP;
				B_INTERP: state_q <= B_ROUND;
				B_ROUND:  state_q <= B_DONE;
				B_DONE:   if (load_out) state_q <= B_IDLE;
				default:  state_q <= B_IDLE;
			endcase
		end
	end

	// Datapath registers; each step of the sequence owns its own register.
	always_ff @(posedge clk) begin
		if (pop) begin
			sum_q <= head.distance_sum;
			clip_q <= head.clip_seen;
		end
		if (state_q == B_MUL_LO) begin
			p_lo_q <= 44'(beta) * 44'(sum_q[19:0]);
		end
		if (state_q == B_MUL_HI) begin
			p_hi_q <= 44'(beta) * 44'(sum_q[39:20]);
		end
		if (state_q == B_SUM) begin
			// Arguments of 16.0 and above flush the activation to zero.
			big_q <= |x_full[63:44];
			x28_q <= x_full[43:12];
		end
		if (state_q == B_LOG) begin
			y_q <= log_prod[62:30];
		end
		if (state_q == B_LUT) begin
			n_q <= y_q[32:28];
			hi_q <= tab_hi;
			diff_q <= (tab_hi >= tab_lo) ? tab_hi - tab_lo : '0;
			r_q <= scaled[27:0];
		end
		if (state_q == B_INTERP) begin
			val_q <= hi_q - interp_prod[58:28];
		end
		if (state_q == B_ROUND) begin
			res_q.activation <= big_q ? '0 : rounded[ACT_W-1:0];
			res_q.sum_saturated <= clip_q;
		end
		if (load_out) begin
			result_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_out) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data = result_q;

endmodule
